// ----- sv/ctil_pkg.sv -----
// ctil_pkg: shared types and constants for the curve table lookup unit
// no dependencies; imported by curve_table_interp_lookup_unit
`default_nettype none

package ctil_pkg;

  // operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_T4D    = 2'd1,
    FUNC_D4T    = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_PLAY_LENGTH  = 1'b1;

  // a segment whose drop is at most this many lsb counts as flat
  localparam logic signed [32:0] FLAT_DROP_LSB = 33'sd7;

  // alpha of one in unsigned q16
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  // controller states, one-hot
  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RD0  = 13'b0000000000010,
    ST_RD1  = 13'b0000000000100,
    ST_CHK  = 13'b0000000001000,
    ST_SRCH = 13'b0000000010000,
    ST_SCMP = 13'b0000000100000,
    ST_RDLO = 13'b0000001000000,
    ST_RDHI = 13'b0000010000000,
    ST_SEG  = 13'b0000100000000,
    ST_DIV  = 13'b0001000000000,
    ST_IDX  = 13'b0010000000000,
    ST_MUL  = 13'b0100000000000,
    ST_FIN  = 13'b1000000000000
  } state_e;

endpackage

`default_nettype wire

// ----- sv/curve_table_interp_lookup_unit.sv -----
// curve_table_interp_lookup_unit: sampled curve store with piecewise-linear lookup
// depends on ctil_pkg; distance and time tables are on-chip synchronous memories
// writes, unused func and an empty curve answer in the cycle after acceptance;
// clamped queries answer from the range check; func 1 runs a binary search and adds a
// divide when the segment is not flat; func 2 runs the bit-serial divider first,
// except when the time is not positive or the play length is zero
// one word in flight at a time; the next word is taken once the result has been taken
// reset (async, active low) clears control and both registers; tables are not cleared
`default_nettype none

module curve_table_interp_lookup_unit #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // config write port
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [30:0]   cfg_data_i,
  // input stream
  input  wire logic          s_axis_tvalid_i,
  output      logic          s_axis_tready_o,
  // lsb up: func[1:0], entry_index[9:2], entry_distance[41:10], entry_time[73:42],
  // query_value[105:74], zero pad[111:106]
  input  wire logic [111:0]  s_axis_tdata_i,
  // result stream
  output      logic          m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // lsb up: result_value[31:0]
  output      logic [31:0]   m_axis_tdata_o
);
  import ctil_pkg::*;

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int PW    = 31 + CW;
  localparam int NUM_W = PW + 16;
  localparam int QI_W  = NUM_W - 16;
  localparam int DCW   = $clog2(NUM_W + 1);

  // input field unpack
  logic [1:0]         in_func;
  logic [7:0]         in_entry;
  logic signed [31:0] in_dist;
  logic signed [31:0] in_time;
  logic signed [31:0] in_query;
  assign in_func  = s_axis_tdata_i[1:0];
  assign in_entry = s_axis_tdata_i[9:2];
  assign in_dist  = s_axis_tdata_i[41:10];
  assign in_time  = s_axis_tdata_i[73:42];
  assign in_query = s_axis_tdata_i[105:74];

  // configuration registers
  logic [8:0]  count_q;
  logic [30:0] play_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      play_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAMPLE_COUNT: count_q <= cfg_data_i[8:0];
        CFG_PLAY_LENGTH:  play_q  <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // active sample count and derived indexes
  logic [CW-1:0] n_act;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] n_m2;
  assign n_act = (32'(count_q) > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : CW'(count_q);
  assign n_m1  = n_act - CW'(1);
  assign n_m2  = n_act - CW'(2);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // datapath registers
  func_e              func_q;
  logic signed [31:0] query_q;
  logic [AW-1:0]      lo_q;
  logic [AW-1:0]      hi_q;
  logic signed [31:0] d0_q;
  logic signed [31:0] t0_q;
  logic signed [31:0] dlo_q;
  logic signed [31:0] tlo_q;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic [16:0]        alpha_q;
  logic signed [50:0] prod_q;
  logic [31:0]        res_q;
  logic [NUM_W-1:0]   num_q;
  logic [NUM_W-1:0]   quot_q;
  logic [32:0]        den_q;
  logic [32:0]        rem_q;
  logic [DCW-1:0]     div_cnt_q;

  // table memories, one shared read address
  logic signed [31:0] dist_mem [MAX_SAMPLES];
  logic signed [31:0] time_mem [MAX_SAMPLES];
  logic signed [31:0] rd_dist_q;
  logic signed [31:0] rd_time_q;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               mem_we;

  assign waddr  = AW'(in_entry);
  assign mem_we = accept && (in_func == FUNC_WRITE) && (32'(in_entry) < MAX_SAMPLES);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dist_mem[waddr] <= in_dist;
      time_mem[waddr] <= in_time;
    end
    rd_dist_q <= dist_mem[raddr];
    rd_time_q <= time_mem[raddr];
  end

  // search midpoint and span
  logic [AW:0]   span;
  logic [AW-1:0] mid;
  assign span = {1'b0, hi_q} - {1'b0, lo_q};
  assign mid  = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  // read address per state
  always_comb begin
    unique case (state_q)
      ST_RD0:  raddr = '0;
      ST_RD1:  raddr = AW'(n_m1);
      ST_SRCH: raddr = mid;
      ST_RDLO: raddr = lo_q;
      ST_RDHI: raddr = hi_q;
      default: raddr = '0;
    endcase
  end

  // segment drop and divider step
  logic signed [32:0] drop;
  logic signed [32:0] dq_diff;
  logic [33:0]        rem_t;
  logic               rem_ge;
  logic [PW-1:0]      p_mul;
  assign drop    = 33'(rd_dist_q) - 33'(dlo_q);
  assign dq_diff = 33'(dlo_q) - 33'(query_q);
  assign rem_t   = {rem_q, num_q[NUM_W-1]};
  assign rem_ge  = rem_t >= {1'b0, den_q};
  assign p_mul   = PW'(query_q[30:0]) * PW'(n_m1);

  // fractional index split for func 2
  logic [QI_W-1:0] qi;
  assign qi = quot_q[NUM_W-1:16];

  // lerp sum
  logic signed [31:0] lerp_res;
  assign lerp_res = a_q + 32'(prod_q >>> 16);

  // next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((in_func == FUNC_T4D || in_func == FUNC_D4T) && n_act != '0) begin
            state_d = ST_RD0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_RD0: state_d = ST_RD1;
      ST_RD1: state_d = ST_CHK;
      ST_CHK: begin
        if (func_q == FUNC_T4D) begin
          if (query_q >= d0_q || query_q < rd_dist_q) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
          end else begin
            state_d = ST_SRCH;
          end
        end else begin
          if (query_q <= t0_q || query_q >= rd_time_q) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
          end else if (query_q > 0 && play_q != '0) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_RDLO;
          end
        end
      end
      ST_SRCH: state_d = (span > (AW+1)'(1)) ? ST_SCMP : ST_RDLO;
      ST_SCMP: state_d = ST_SRCH;
      ST_RDLO: state_d = ST_RDHI;
      ST_RDHI: state_d = ST_SEG;
      ST_SEG: begin
        if (func_q == FUNC_T4D && drop < -FLAT_DROP_LSB) state_d = ST_DIV;
        else                                             state_d = ST_MUL;
      end
      ST_DIV: begin
        if (div_cnt_q == DCW'(1)) state_d = (func_q == FUNC_T4D) ? ST_MUL : ST_IDX;
      end
      ST_IDX: state_d = ST_RDLO;
      ST_MUL: state_d = ST_FIN;
      ST_FIN: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath updates
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_q  <= func_e'(in_func);
          query_q <= in_query;
          res_q   <= '0;
        end
      end
      ST_RD1: begin
        d0_q <= rd_dist_q;
        t0_q <= rd_time_q;
      end
      ST_CHK: begin
        lo_q <= '0;
        if (func_q == FUNC_T4D) begin
          hi_q  <= AW'(n_m1);
          res_q <= (query_q >= d0_q) ? t0_q : rd_time_q;
        end else begin
          hi_q      <= AW'(1);
          alpha_q   <= '0;
          res_q     <= (query_q <= t0_q) ? d0_q : rd_dist_q;
          num_q     <= {p_mul, 16'h0000};
          quot_q    <= '0;
          rem_q     <= '0;
          den_q     <= {2'b00, play_q};
          div_cnt_q <= DCW'(NUM_W);
        end
      end
      ST_SCMP: begin
        if (rd_dist_q <= query_q) hi_q <= mid;
        else                      lo_q <= mid;
      end
      ST_RDHI: begin
        dlo_q <= rd_dist_q;
        tlo_q <= rd_time_q;
      end
      ST_SEG: begin
        if (func_q == FUNC_T4D) begin
          a_q       <= tlo_q;
          b_q       <= rd_time_q;
          alpha_q   <= ALPHA_ONE;
          num_q     <= NUM_W'({dq_diff[31:0], 16'h0000});
          quot_q    <= '0;
          rem_q     <= '0;
          den_q     <= -drop;
          div_cnt_q <= DCW'(NUM_W);
        end else begin
          a_q <= dlo_q;
          b_q <= rd_dist_q;
        end
      end
      ST_DIV: begin
        num_q     <= num_q << 1;
        quot_q    <= {quot_q[NUM_W-2:0], rem_ge};
        rem_q     <= rem_ge ? 33'(rem_t - {1'b0, den_q}) : rem_t[32:0];
        div_cnt_q <= div_cnt_q - DCW'(1);
        if (div_cnt_q == DCW'(1) && func_q == FUNC_T4D) begin
          alpha_q <= {quot_q[15:0], rem_ge};
        end
      end
      ST_IDX: begin
        if (qi > QI_W'(n_m2)) begin
          lo_q    <= AW'(n_m2);
          hi_q    <= AW'(n_m2) + AW'(1);
          alpha_q <= ALPHA_ONE;
        end else begin
          lo_q    <= AW'(qi);
          hi_q    <= AW'(qi) + AW'(1);
          alpha_q <= {1'b0, quot_q[15:0]};
        end
      end
      ST_MUL: prod_q <= (33'(b_q) - 33'(a_q)) * $signed({1'b0, alpha_q});
      ST_FIN: res_q  <= lerp_res;
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

endmodule

`default_nettype wire
